// ----- rtl/ppce_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppce_pkg - shared types and constants of the packet-pair capacity estimator
// Field widths, register indexes, reset values and the sequencer states.
// ----------------------------------------------------------------------------
package ppce_pkg;

  // field widths
  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SEQ_W   = 32;
  localparam int unsigned SIZE_W  = 16;
  localparam int unsigned OVH_W   = 8;
  localparam int unsigned TIME_W  = 48;
  localparam int unsigned CAP_W   = 29;
  localparam int unsigned CNT_W   = 16;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 1;

  // numerator (size + overhead) * 8000 always fits in CAP_W bits
  localparam int unsigned SUM_W   = SIZE_W + 1;
  localparam int unsigned NUM_W   = CAP_W;
  localparam int unsigned PROD_W  = SUM_W + 13;
  localparam logic [12:0] BITS_PER_BYTE_MS = 13'd8000;

  // divider iteration counter
  localparam int unsigned ITER_W  = $clog2(NUM_W + 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PAIR_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_OVERHEAD = 1'd1;

  // register reset values
  localparam logic [SIZE_W-1:0] MIN_PAIR_SIZE_RST   = 16'd500;
  localparam logic [OVH_W-1:0]  HEADER_OVERHEAD_RST = 8'd40;

  // sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_START,
    ST_DIV,
    ST_LOAD
  } state_e;

  // one result item
  typedef struct packed {
    logic              sample_valid;
    logic [CAP_W-1:0]  capacity_kbps;
    logic [TIME_W-1:0] gap_us;
    logic              duplicate_first;
    logic              summary_valid;
    logic [KEY_W-1:0]  summary_flow;
    logic [SIZE_W-1:0] summary_size;
    logic [CNT_W-1:0]  summary_count;
  } res_t;

  // saturating 16-bit increment
  function automatic logic [CNT_W-1:0] inc_sat(input logic [CNT_W-1:0] v);
    inc_sat = (v == {CNT_W{1'b1}}) ? v : v + {{(CNT_W-1){1'b0}}, 1'b1};
  endfunction

endpackage

// ----- rtl/ppce_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppce_div - iterative restoring divider
// Divides the capacity numerator by the packet gap, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module ppce_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [ppce_pkg::NUM_W-1:0]  dividend_i,
  input  logic [ppce_pkg::TIME_W-1:0] divisor_i,
  output logic                        done_o,
  output logic [ppce_pkg::NUM_W-1:0]  quotient_o
);
  import ppce_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [ITER_W-1:0] cnt_q, cnt_d;
  logic [NUM_W-1:0]  quo_q, quo_d;
  logic [NUM_W-1:0]  rem_q, rem_d;

  logic [NUM_W:0]    rem_sh;
  logic [NUM_W:0]    diff;
  logic              fits;

  // one restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem_q, quo_q[NUM_W-1]};
    fits   = {{(TIME_W-NUM_W-1){1'b0}}, rem_sh} >= divisor_i;
    diff   = rem_sh - divisor_i[NUM_W:0];
  end

  // iteration control
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = ITER_W'(NUM_W);
      quo_d  = dividend_i;
      rem_d  = '0;
    end else if (busy_q) begin
      // remainder stays below the partial dividend, so it fits NUM_W bits
      rem_d = fits ? diff[NUM_W-1:0] : rem_sh[NUM_W-1:0];
      quo_d = {quo_q[NUM_W-2:0], fits};
      cnt_d = cnt_q - ITER_W'(1);
      if (cnt_q == ITER_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ----- rtl/packet_pair_capacity_estimator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_pair_capacity_estimator_top - packet-pair capacity estimator
// Finds back-to-back equal-size packets of one flow and ack, gives a capacity
// sample per qualifying pair and a pair record when a chain with enough pairs ends.
// ----------------------------------------------------------------------------
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------
//  input    | in_valid_i / in_ready_o  | has_ack_i .. time_us_i
//  output   | out_valid_o / out_ready_i| sample_valid_o .. summary_count_o
//  config   | cfg_we_i                 | cfg_index_i, cfg_data_i
//
//  an item that yields a capacity sample goes from transfer to result through
//  multiply, divider start, 29 restoring steps, done flag, output load.
//  input is ready again after the output load; other items go straight to the load.
//  the result register frees the input side: a new item is taken while the
//  previous result waits; the load waits only if that register is still full.
//  reset clears all flow state and restores the register defaults.
// ----------------------------------------------------------------------------
module packet_pair_capacity_estimator_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // configuration
  input  logic                           cfg_we_i,
  input  logic [ppce_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [ppce_pkg::CFG_W-1:0]     cfg_data_i,
  // input records
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic                           has_ack_i,
  input  logic [ppce_pkg::KEY_W-1:0]     flow_key_i,
  input  logic [ppce_pkg::SEQ_W-1:0]     ack_number_i,
  input  logic [ppce_pkg::SEQ_W-1:0]     seq_start_i,
  input  logic [ppce_pkg::SEQ_W-1:0]     seq_end_i,
  input  logic [ppce_pkg::SIZE_W-1:0]    payload_size_i,
  input  logic [ppce_pkg::TIME_W-1:0]    time_us_i,
  // results
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic                           sample_valid_o,
  output logic [ppce_pkg::CAP_W-1:0]     capacity_kbps_o,
  output logic [ppce_pkg::TIME_W-1:0]    gap_us_o,
  output logic                           duplicate_first_o,
  output logic                           summary_valid_o,
  output logic [ppce_pkg::KEY_W-1:0]     summary_flow_o,
  output logic [ppce_pkg::SIZE_W-1:0]    summary_size_o,
  output logic [ppce_pkg::CNT_W-1:0]     summary_count_o
);
  import ppce_pkg::*;

  // configuration registers
  logic [SIZE_W-1:0] min_size_q;
  logic [OVH_W-1:0]  ovh_q;

  // flow state
  logic              flow_vld_q, flow_vld_d;
  logic [KEY_W-1:0]  last_flow_q, last_flow_d;
  logic [SEQ_W-1:0]  last_ack_q, last_ack_d;
  logic [CNT_W-1:0]  run_count_q, run_count_d;
  logic [SIZE_W-1:0] run_size_q, run_size_d;
  logic [TIME_W-1:0] last_time_q, last_time_d;
  logic [SEQ_W-1:0]  last_ss_q, last_ss_d;
  logic [SEQ_W-1:0]  last_se_q, last_se_d;
  logic [CNT_W-1:0]  dup_run_q, dup_run_d;
  logic [CNT_W-1:0]  pair_count_q, pair_count_d;
  logic [SIZE_W-1:0] pair_size_q, pair_size_d;
  logic [KEY_W-1:0]  sum_key_q, sum_key_d;

  // sequencer and datapath
  state_e            state_q, state_d;
  res_t              res_q, res_d;
  logic [SUM_W-1:0]  sum_q, sum_d;
  logic [TIME_W-1:0] gap_q, gap_d;
  logic [NUM_W-1:0]  num_q;
  logic [PROD_W-1:0] prod;
  res_t              out_q;
  logic              out_valid_q;

  logic              accept;
  logic              out_free;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [NUM_W-1:0]  div_quo;

  // chain decode signals
  logic              match;
  logic [CNT_W-1:0]  rc_inc;
  logic              pair_cond;
  logic              dup;

  assign accept   = in_valid_i && in_ready_o;
  assign out_free = !out_valid_q || out_ready_i;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_size_q <= MIN_PAIR_SIZE_RST;
      ovh_q      <= HEADER_OVERHEAD_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_MIN_PAIR_SIZE:   min_size_q <= cfg_data_i;
        CFG_HEADER_OVERHEAD: ovh_q      <= cfg_data_i[OVH_W-1:0];
        default: ;
      endcase
    end
  end

  // chain tracking and result decode for one record
  always_comb begin
    match     = flow_vld_q && (flow_key_i == last_flow_q) && (ack_number_i == last_ack_q);
    rc_inc    = inc_sat(run_count_q);
    pair_cond = (rc_inc > CNT_W'(1)) && (run_size_q == payload_size_i) &&
                (run_size_q != '0);
    dup       = (seq_start_i == last_ss_q) && (seq_end_i == last_se_q);

    flow_vld_d   = flow_vld_q;
    last_flow_d  = last_flow_q;
    last_ack_d   = last_ack_q;
    run_count_d  = run_count_q;
    run_size_d   = run_size_q;
    last_time_d  = last_time_q;
    last_ss_d    = last_ss_q;
    last_se_d    = last_se_q;
    dup_run_d    = dup_run_q;
    pair_count_d = pair_count_q;
    pair_size_d  = pair_size_q;
    sum_key_d    = sum_key_q;
    res_d        = '0;
    gap_d        = time_us_i - last_time_q;
    sum_d        = {1'b0, run_size_q} + {{(SUM_W-OVH_W){1'b0}}, ovh_q};

    if (!has_ack_i) begin
      // non-ack record breaks the chain
      flow_vld_d = 1'b0;
    end else if (match) begin
      run_count_d = rc_inc;
      if (pair_cond) begin
        last_ss_d = seq_start_i;
        last_se_d = seq_end_i;
        if (!dup) begin
          dup_run_d          = '0;
          res_d.sample_valid = (run_size_q >= min_size_q) && (time_us_i > last_time_q);
          res_d.gap_us       = res_d.sample_valid ? gap_d : '0;
          pair_count_d       = inc_sat(pair_count_q);
          pair_size_d        = run_size_q;
        end else begin
          dup_run_d             = inc_sat(dup_run_q);
          res_d.duplicate_first = (dup_run_q == '0);
        end
      end
      if (run_size_q != payload_size_i) begin
        run_count_d = '0;
        run_size_d  = payload_size_i;
      end
      last_time_d = time_us_i;
      last_flow_d = flow_key_i;
      flow_vld_d  = 1'b1;
    end else begin
      // new chain: report the ended one if it held enough pairs
      if ((pair_count_q > CNT_W'(1)) && (pair_size_q >= min_size_q)) begin
        res_d.summary_valid = 1'b1;
        res_d.summary_flow  = sum_key_q;
        res_d.summary_size  = pair_size_q;
        res_d.summary_count = pair_count_q;
      end
      last_time_d  = time_us_i;
      run_size_d   = payload_size_i;
      last_ss_d    = '0;
      last_se_d    = '0;
      last_ack_d   = ack_number_i;
      pair_count_d = '0;
      pair_size_d  = payload_size_i;
      sum_key_d    = flow_key_i;
      run_count_d  = CNT_W'(1);
      last_flow_d  = flow_key_i;
      flow_vld_d   = 1'b1;
    end
  end

  // flow state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flow_vld_q   <= 1'b0;
      last_flow_q  <= '0;
      last_ack_q   <= '0;
      run_count_q  <= '0;
      run_size_q   <= '0;
      last_time_q  <= '0;
      last_ss_q    <= '0;
      last_se_q    <= '0;
      dup_run_q    <= '0;
      pair_count_q <= '0;
      pair_size_q  <= '0;
      sum_key_q    <= '0;
    end else if (accept) begin
      flow_vld_q   <= flow_vld_d;
      last_flow_q  <= last_flow_d;
      last_ack_q   <= last_ack_d;
      run_count_q  <= run_count_d;
      run_size_q   <= run_size_d;
      last_time_q  <= last_time_d;
      last_ss_q    <= last_ss_d;
      last_se_q    <= last_se_d;
      dup_run_q    <= dup_run_d;
      pair_count_q <= pair_count_d;
      pair_size_q  <= pair_size_d;
      sum_key_q    <= sum_key_d;
    end
  end

  // sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept) state_d = res_d.sample_valid ? ST_MUL : ST_LOAD;
      ST_MUL:   state_d = ST_START;
      ST_START: state_d = ST_DIV;
      ST_DIV:   if (div_done) state_d = ST_LOAD;
      ST_LOAD:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // sequencer: outputs
  always_comb begin
    in_ready_o = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE:  in_ready_o = 1'b1;
      ST_START: div_start  = 1'b1;
      ST_LOAD:  out_load   = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // numerator of the capacity sample
  assign prod = sum_q * BITS_PER_BYTE_MS;

  // pending result and operands
  always_ff @(posedge clk_i) begin
    if (accept) begin
      res_q <= res_d;
      sum_q <= sum_d;
      gap_q <= gap_d;
    end else if (div_done) begin
      // quotient never exceeds the numerator, so it cannot pass the cap
      res_q.capacity_kbps <= div_quo;
    end
    if (state_q == ST_MUL) begin
      num_q <= prod[NUM_W-1:0];
    end
  end

  // single divider for all capacity samples
  ppce_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (num_q),
    .divisor_i  (gap_q),
    .done_o     (div_done),
    .quotient_o (div_quo)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign sample_valid_o    = out_q.sample_valid;
  assign capacity_kbps_o   = out_q.capacity_kbps;
  assign gap_us_o          = out_q.gap_us;
  assign duplicate_first_o = out_q.duplicate_first;
  assign summary_valid_o   = out_q.summary_valid;
  assign summary_flow_o    = out_q.summary_flow;
  assign summary_size_o    = out_q.summary_size;
  assign summary_count_o   = out_q.summary_count;

  // checks
  a_done_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside the divide state");

  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !in_ready_o)
    else $error("second record taken while one is in work");

  a_kinds_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(sample_valid_o && summary_valid_o))
    else $error("sample and summary in the same result");

  a_gap_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && sample_valid_o) |-> (gap_us_o != '0))
    else $error("sample with zero gap");

endmodule

// ----- sim/packet_pair_capacity_estimator_top_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_pair_capacity_estimator_top_test - self-checking bench for the estimator
// Drives packet records over the input handshake and keeps its own model of the
// chain, pair and duplicate tracking. Each result transfer is checked field by
// field against the oldest expected result. Covers directed corner records,
// random flow chains under several register settings and idle patterns, and
// long output back-pressure stretches.
// ----------------------------------------------------------------------------
module packet_pair_capacity_estimator_top_test;
  import ppce_pkg::*;

  localparam int unsigned STALL_LIMIT  = 4000;
  localparam int unsigned SETTLE_TICKS = 40;
  localparam int unsigned HOLD_TICKS   = 250;
  localparam logic [63:0] CAP_CEILING  = (64'd1 << CAP_W) - 64'd1;

  // one packet record as offered on the input channel
  typedef struct packed {
    logic              has_ack;
    logic [KEY_W-1:0]  flow_key;
    logic [SEQ_W-1:0]  ack_number;
    logic [SEQ_W-1:0]  seq_start;
    logic [SEQ_W-1:0]  seq_end;
    logic [SIZE_W-1:0] payload_size;
    logic [TIME_W-1:0] time_us;
  } packet_rec_t;

  // chain tracking, expected results and mismatch bookkeeping
  class capacity_tracker;
    logic [SIZE_W-1:0] min_size;
    logic [OVH_W-1:0]  overhead;
    logic [KEY_W-1:0]  prev_flow;
    logic              prev_flow_ok;
    logic [SEQ_W-1:0]  prev_ack;
    logic [CNT_W-1:0]  chain_len;
    logic [SIZE_W-1:0] chain_size;
    logic [TIME_W-1:0] prev_time;
    logic [SEQ_W-1:0]  prev_seq_start;
    logic [SEQ_W-1:0]  prev_seq_end;
    logic [CNT_W-1:0]  dup_len;
    logic [CNT_W-1:0]  pairs;
    logic [SIZE_W-1:0] pairs_size;
    logic [KEY_W-1:0]  chain_key;
    res_t              expected_results[$];
    int unsigned       mismatches;
    int unsigned       failures;

    function new();
      min_size       = MIN_PAIR_SIZE_RST;
      overhead       = HEADER_OVERHEAD_RST;
      prev_flow      = '0;
      prev_flow_ok   = 1'b0;
      prev_ack       = '0;
      chain_len      = '0;
      chain_size     = '0;
      prev_time      = '0;
      prev_seq_start = '0;
      prev_seq_end   = '0;
      dup_len        = '0;
      pairs          = '0;
      pairs_size     = '0;
      chain_key      = '0;
      mismatches     = 0;
      failures       = 0;
    endfunction

    function logic [CNT_W-1:0] bump(logic [CNT_W-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
      if (idx == CFG_MIN_PAIR_SIZE) begin
        min_size = value[SIZE_W-1:0];
      end else if (idx == CFG_HEADER_OVERHEAD) begin
        overhead = value[OVH_W-1:0];
      end
    endfunction

    // work out the result of one accepted record
    function void note_record(packet_rec_t r);
      res_t              e;
      logic              dup;
      logic [TIME_W-1:0] gap;
      logic [63:0]       num;
      logic [63:0]       quo;
      e = '0;
      if (!r.has_ack) begin
        prev_flow_ok = 1'b0;
      end else begin
        if (prev_flow_ok && r.flow_key == prev_flow && r.ack_number == prev_ack) begin
          chain_len = bump(chain_len);
          if (chain_len > 1 && chain_size == r.payload_size && chain_size != 0) begin
            dup = (r.seq_start == prev_seq_start && r.seq_end == prev_seq_end);
            prev_seq_start = r.seq_start;
            prev_seq_end   = r.seq_end;
            if (!dup) begin
              dup_len = '0;
              if (chain_size >= min_size && r.time_us > prev_time) begin
                gap = r.time_us - prev_time;
                num = chain_size;
                num = (num + overhead) * 64'd8000;
                quo = num / gap;
                if (quo > CAP_CEILING) quo = CAP_CEILING;
                e.sample_valid  = 1'b1;
                e.capacity_kbps = quo[CAP_W-1:0];
                e.gap_us        = gap;
              end
              pairs      = bump(pairs);
              pairs_size = chain_size;
            end else begin
              dup_len = bump(dup_len);
              if (dup_len == 1) e.duplicate_first = 1'b1;
            end
          end
          if (chain_size != r.payload_size) begin
            chain_len  = '0;
            chain_size = r.payload_size;
          end
          prev_time = r.time_us;
        end else begin
          // a new chain starts: report the one that ended
          if (pairs > 1 && pairs_size >= min_size) begin
            e.summary_valid = 1'b1;
            e.summary_flow  = chain_key;
            e.summary_size  = pairs_size;
            e.summary_count = pairs;
          end
          prev_time      = r.time_us;
          chain_size     = r.payload_size;
          prev_seq_start = '0;
          prev_seq_end   = '0;
          prev_ack       = r.ack_number;
          pairs          = '0;
          pairs_size     = r.payload_size;
          chain_key      = r.flow_key;
          chain_len      = CNT_W'(1);
        end
        prev_flow    = r.flow_key;
        prev_flow_ok = 1'b1;
      end
      expected_results.push_back(e);
    endfunction

    function void report(string what, logic [63:0] want, logic [63:0] got);
      failures++;
      if (mismatches < 10) begin
        $display("%0t: %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      end
      mismatches++;
    endfunction

    function void compare_field(string what, logic [63:0] want, logic [63:0] got);
      if (got !== want) report(what, want, got);
    endfunction

    // compare one result transfer with the oldest expectation
    function void check_result(res_t got);
      res_t e;
      if (expected_results.size() == 0) begin
        report("result with nothing pending", 64'd0, 64'd1);
      end else begin
        e = expected_results.pop_front();
        compare_field("sample_valid", e.sample_valid, got.sample_valid);
        compare_field("capacity_kbps", e.capacity_kbps, got.capacity_kbps);
        compare_field("gap_us", e.gap_us, got.gap_us);
        compare_field("duplicate_first", e.duplicate_first, got.duplicate_first);
        compare_field("summary_valid", e.summary_valid, got.summary_valid);
        compare_field("summary_flow", e.summary_flow, got.summary_flow);
        compare_field("summary_size", e.summary_size, got.summary_size);
        compare_field("summary_count", e.summary_count, got.summary_count);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  in_valid_i;
  logic                  in_ready_o;
  logic                  has_ack_i;
  logic [KEY_W-1:0]      flow_key_i;
  logic [SEQ_W-1:0]      ack_number_i;
  logic [SEQ_W-1:0]      seq_start_i;
  logic [SEQ_W-1:0]      seq_end_i;
  logic [SIZE_W-1:0]     payload_size_i;
  logic [TIME_W-1:0]     time_us_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  logic                  sample_valid_o;
  logic [CAP_W-1:0]      capacity_kbps_o;
  logic [TIME_W-1:0]     gap_us_o;
  logic                  duplicate_first_o;
  logic                  summary_valid_o;
  logic [KEY_W-1:0]      summary_flow_o;
  logic [SIZE_W-1:0]     summary_size_o;
  logic [CNT_W-1:0]      summary_count_o;

  capacity_tracker       tracker;
  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  int unsigned           hold_request;
  int unsigned           quiet_cycles;
  logic [TIME_W-1:0]     stamp;
  logic [KEY_W-1:0]      flow_pool [4];

  packet_pair_capacity_estimator_top u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .has_ack_i         (has_ack_i),
    .flow_key_i        (flow_key_i),
    .ack_number_i      (ack_number_i),
    .seq_start_i       (seq_start_i),
    .seq_end_i         (seq_end_i),
    .payload_size_i    (payload_size_i),
    .time_us_i         (time_us_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .sample_valid_o    (sample_valid_o),
    .capacity_kbps_o   (capacity_kbps_o),
    .gap_us_o          (gap_us_o),
    .duplicate_first_o (duplicate_first_o),
    .summary_valid_o   (summary_valid_o),
    .summary_flow_o    (summary_flow_o),
    .summary_size_o    (summary_size_o),
    .summary_count_o   (summary_count_o)
  );

  // 10 ns clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result side: random ready, long hold-off on request
  initial begin : result_sink
    int unsigned hold_left;
    hold_left   = 0;
    out_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready_i = 1'b0;
        hold_left--;
      end else begin
        out_ready_i = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // check every result transfer
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      tracker.check_result({sample_valid_o, capacity_kbps_o, gap_us_o, duplicate_first_o,
                            summary_valid_o, summary_flow_o, summary_size_o,
                            summary_count_o});
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $realtime, quiet_cycles);
        $display("FAILURE");
        $finish;
      end
    end
  end

  function automatic packet_rec_t make_rec(logic ack_flag, logic [KEY_W-1:0] flow,
                                           logic [SEQ_W-1:0] ack, logic [SEQ_W-1:0] s0,
                                           logic [SEQ_W-1:0] s1, logic [SIZE_W-1:0] size,
                                           logic [TIME_W-1:0] t);
    packet_rec_t r;
    r.has_ack      = ack_flag;
    r.flow_key     = flow;
    r.ack_number   = ack;
    r.seq_start    = s0;
    r.seq_end      = s1;
    r.payload_size = size;
    r.time_us      = t;
    return r;
  endfunction

  function automatic packet_rec_t random_record();
    logic [63:0] wide;
    wide = {$urandom, $urandom};
    return make_rec(1'($urandom_range(1)), $urandom, $urandom, $urandom, $urandom,
                    SIZE_W'($urandom_range(65535)), wide[TIME_W-1:0]);
  endfunction

  // payload sizes around the current pair threshold and at the extremes
  function automatic logic [SIZE_W-1:0] pick_size();
    logic [SIZE_W-1:0] floor_size;
    floor_size = tracker.min_size;
    case ($urandom_range(9))
      0: return '0;
      1: return '1;
      2: return floor_size;
      3: return (floor_size == 0) ? floor_size : floor_size - 1'b1;
      4: return SIZE_W'($urandom_range(65535));
      default: return SIZE_W'($urandom_range(65535, floor_size));
    endcase
  endfunction

  // offer one record and wait for its transfer; entered and left at a falling edge
  task automatic send_record(input packet_rec_t r);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i = 1'b0;
      @(negedge clk_i);
    end
    in_valid_i     = 1'b1;
    has_ack_i      = r.has_ack;
    flow_key_i     = r.flow_key;
    ack_number_i   = r.ack_number;
    seq_start_i    = r.seq_start;
    seq_end_i      = r.seq_end;
    payload_size_i = r.payload_size;
    time_us_i      = r.time_us;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.note_record(r);
    @(negedge clk_i);
  endtask

  // let every expected result arrive and the divider go quiet
  task automatic wait_drained();
    in_valid_i = 1'b0;
    while (tracker.expected_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_TICKS) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_index_i = idx;
    cfg_data_i  = value;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    tracker.set_register(idx, value);
  endtask

  // one flow chain: same flow and ack, with duplicates, size and ack changes,
  // stalled or backward time and stray records mixed in
  task automatic send_chain(input int unsigned len);
    packet_rec_t r;
    logic [63:0] wide;
    int unsigned i;
    r.has_ack      = 1'b1;
    r.flow_key     = ($urandom_range(2) == 0) ? flow_pool[$urandom_range(3)] : $urandom;
    r.ack_number   = $urandom;
    r.payload_size = pick_size();
    r.seq_end      = $urandom;
    if ($urandom_range(9) == 0) begin
      wide  = {$urandom, $urandom};
      stamp = wide[TIME_W-1:0];
    end
    for (i = 0; i < len; i++) begin
      case ($urandom_range(99)) inside
        [0:9]: begin
          // resend the previous span; the first record gets a fresh one
          if (i == 0) begin
            r.seq_start = r.seq_end;
            r.seq_end   = r.seq_start + r.payload_size;
          end
        end
        [10:12]: begin
          r.payload_size = pick_size();
          r.seq_start    = r.seq_end;
          r.seq_end      = r.seq_start + r.payload_size;
        end
        [13:15]: begin
          r.ack_number = $urandom;
          r.seq_start  = r.seq_end;
          r.seq_end    = r.seq_start + r.payload_size;
        end
        [16:18]: begin
          r.seq_start = $urandom;
          r.seq_end   = $urandom;
        end
        default: begin
          r.seq_start = r.seq_end;
          r.seq_end   = r.seq_start + r.payload_size;
        end
      endcase
      case ($urandom_range(19))
        0: ;
        1: stamp = stamp - $urandom_range(500, 1);
        2: stamp = stamp + $urandom;
        default: stamp = stamp + $urandom_range(3000, 1);
      endcase
      r.time_us = stamp;
      if ($urandom_range(99) < 4) send_record(random_record());
      send_record(r);
    end
  endtask

  task automatic random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned len;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_record(random_record());
        sent++;
      end else begin
        len = $urandom_range(10, 1);
        send_chain(len);
        sent += len;
      end
    end
  endtask

  // directed corner records under the reset register values
  task automatic directed_records();
    logic [KEY_W-1:0] fa;
    fa = 32'h1234_5678;
    send_record(make_rec(1'b0, '1, '1, '1, '1, '1, '1));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd0, 32'd1500, 16'd1500, 48'd1000));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd1500, 32'd3000, 16'd1500, 48'd1100));
    // time not advancing
    send_record(make_rec(1'b1, fa, 32'd1, 32'd3000, 32'd4500, 16'd1500, 48'd1100));
    // repeated span, then repeated again
    send_record(make_rec(1'b1, fa, 32'd1, 32'd3000, 32'd4500, 16'd1500, 48'd1200));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd3000, 32'd4500, 16'd1500, 48'd1300));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd4500, 32'd6000, 16'd1500, 48'd1400));
    // time going backward
    send_record(make_rec(1'b1, fa, 32'd1, 32'd6000, 32'd7500, 16'd1500, 48'd900));
    // size change to exactly the threshold
    send_record(make_rec(1'b1, fa, 32'd1, 32'd7500, 32'd8000, 16'd500, 48'd2000));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd8000, 32'd8500, 16'd500, 48'd2100));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd8500, 32'd9000, 16'd500, 48'd2200));
    // just below the threshold
    send_record(make_rec(1'b1, fa, 32'd1, 32'd9000, 32'd9499, 16'd499, 48'd2300));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd9499, 32'd9998, 16'd499, 48'd2400));
    send_record(make_rec(1'b1, fa, 32'd1, 32'd9998, 32'd10497, 16'd499, 48'd2500));
    // largest size, time from zero to one, then gap of one and largest gap
    send_record(make_rec(1'b1, '1, '0, 32'd0, 32'd0, 16'hFFFF, 48'd0));
    send_record(make_rec(1'b1, '1, '0, 32'd0, 32'd65535, 16'hFFFF, 48'd1));
    send_record(make_rec(1'b1, '1, '0, 32'd65535, 32'd131070, 16'hFFFF, 48'd2));
    send_record(make_rec(1'b1, '1, '0, 32'd131070, 32'd196605, 16'hFFFF, '1));
    // same flow under a new ack ends the chain; zero-size records never pair
    send_record(make_rec(1'b1, fa, 32'd2, 32'd0, 32'd0, 16'd0, 48'd10));
    send_record(make_rec(1'b1, fa, 32'd2, 32'd0, 32'd0, 16'd0, 48'd20));
    send_record(make_rec(1'b1, fa, 32'd2, 32'd0, 32'd0, 16'd0, 48'd30));
    // non-ack record breaks the chain
    send_record(make_rec(1'b0, fa, 32'd2, 32'd0, 32'd0, 16'd0, 48'd40));
    send_record(make_rec(1'b1, fa, 32'd2, '1, '1, 16'd0, 48'd50));
  endtask

  // main sequence
  initial begin : main_flow
    logic [CFG_W-1:0] min_set [6];
    logic [OVH_W-1:0] ovh_set [6];
    logic [CFG_W-1:0] data;
    int unsigned      p;
    int unsigned      k;
    tracker        = new();
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_index_i    = CFG_MIN_PAIR_SIZE;
    cfg_data_i     = '0;
    in_valid_i     = 1'b0;
    has_ack_i      = 1'b0;
    flow_key_i     = '0;
    ack_number_i   = '0;
    seq_start_i    = '0;
    seq_end_i      = '0;
    payload_size_i = '0;
    time_us_i      = '0;
    tx_idle_pct    = 38;
    rx_idle_pct    = 64;
    hold_request   = 0;
    quiet_cycles   = 0;
    stamp          = 48'd100000;
    for (k = 0; k < 4; k++) flow_pool[k] = $urandom;
    min_set = '{16'd0, 16'hFFFF, 16'd1500, CFG_W'($urandom_range(2000)), 16'd500, 16'd1};
    ovh_set = '{8'hFF, 8'd0, 8'd40, OVH_W'($urandom_range(255)), 8'hFF, 8'd128};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    directed_records();

    for (p = 0; p < 3; p++) begin
      // receiver-heavy idling, then sender-heavy, then none
      tx_idle_pct = (p == 0) ? 38 : (p == 1) ? 64 : 0;
      rx_idle_pct = (p == 0) ? 64 : (p == 1) ? 38 : 0;
      for (k = 0; k < 2; k++) begin
        wait_drained();
        write_register(CFG_MIN_PAIR_SIZE, min_set[2*p+k]);
        data = CFG_W'($urandom);
        data[OVH_W-1:0] = ovh_set[2*p+k];
        write_register(CFG_HEADER_OVERHEAD, data);
        if (k == 0) hold_request = HOLD_TICKS;
        random_traffic(265);
      end
    end

    wait_drained();
    if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
